>>> rtl/assert_macros.svh
// Assertion macros shared by the stack arithmetic unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset.
`define SAU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked also during reset.
`define SAU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/sau_pkg.sv
// Types and codes of the stack arithmetic unit.
package sau_pkg;

   localparam logic [2:0] OP_PUSH = 3'd0;
   localparam logic [2:0] OP_ADD  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_DIV  = 3'd3;
   localparam logic [2:0] OP_MUL  = 3'd4;
   localparam logic [2:0] OP_SWAP = 3'd5;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_SHORT   = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   typedef struct packed {
      logic [2:0]          operation;
      logic signed [31:0]  push_value;
   } req_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  top_value;
      logic [6:0]          stack_depth;
   } rsp_type;

   typedef struct packed {
      logic       load_req;
      logic       push;
      logic       rd_en;
      logic       swap;
      logic       arith;
      logic       div_start;
      logic       div_load;
      logic [2:0] alu_op;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic short_stack;
      logic top_zero;
      logic div_done;
   } dp_stat_type;

endpackage

>>> rtl/sau_divider.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
module sau_divider import sau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic [31:0] quotient,
   output logic        done
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] quo_ff, quo_in;
   logic [31:0] dvs_ff, dvs_in;
   logic        neg_ff, neg_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;

   logic [32:0] rem_sh;
   logic [32:0] diff;
   logic        ge;

   assign rem_sh = {rem_ff, quo_ff[31]};
   assign diff   = rem_sh - {1'b0, dvs_ff};
   assign ge     = !diff[32];

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in = '0;
         quo_in = dividend[31] ? (32'd0 - dividend) : dividend;
         dvs_in = divisor[31] ? (32'd0 - divisor) : divisor;
         neg_in = dividend[31] ^ divisor[31];
         cnt_in = '0;
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = ge ? diff[31:0] : rem_sh[31:0];
         quo_in = {quo_ff[30:0], ge};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   assign quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;
   assign done     = done_ff;

endmodule

>>> rtl/sau_datapath.sv
// Stack datapath: top register, stack memory, ALU and divider.
module sau_datapath import sau_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  req_type     req_data,
   input  dp_cmd_type  cmd,
   output dp_stat_type stat,
   output logic [31:0] top_value,
   output logic [6:0]  stack_depth
);

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   logic [31:0]   mem [STACK_DEPTH];
   logic [31:0]   val_ff;
   logic [31:0]   top_ff, top_in;
   logic [CW-1:0] depth_ff, depth_in;
   logic [31:0]   rd_data_ff;

   logic [CW-1:0] depth_m1, depth_m2;
   logic [AW-1:0] addr_m1, addr_m2, waddr;
   logic          mem_we;
   logic [31:0]   alu_res;
   logic [31:0]   quotient;
   logic          div_done;
   logic [CW+6:0] depth_wide;

   assign depth_m1 = depth_ff - CW'(1);
   assign depth_m2 = depth_ff - CW'(2);
   assign addr_m1  = depth_m1[AW-1:0];
   assign addr_m2  = depth_m2[AW-1:0];
   assign mem_we   = (cmd.push && (depth_ff != '0)) || cmd.swap;
   assign waddr    = cmd.push ? addr_m1 : addr_m2;

   sau_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (rd_data_ff),
      .divisor  (top_ff),
      .quotient (quotient),
      .done     (div_done)
   );

   always_comb begin
      unique case (cmd.alu_op)
         OP_SUB:  alu_res = rd_data_ff - top_ff;
         OP_MUL:  alu_res = rd_data_ff * top_ff;
         default: alu_res = rd_data_ff + top_ff;
      endcase
   end

   always_comb begin
      top_in   = top_ff;
      depth_in = depth_ff;
      priority if (cmd.push) begin
         top_in   = val_ff;
         depth_in = depth_ff + CW'(1);
      end else if (cmd.swap) begin
         top_in = rd_data_ff;
      end else if (cmd.arith) begin
         top_in   = alu_res;
         depth_in = depth_m1;
      end else if (cmd.div_load) begin
         top_in   = quotient;
         depth_in = depth_m1;
      end else begin
         top_in   = top_ff;
         depth_in = depth_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= top_ff;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[addr_m2];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         val_ff <= req_data.push_value;
      end
      top_ff <= top_in;
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   assign stat.full        = (depth_ff == CW'(STACK_DEPTH));
   assign stat.short_stack = (depth_ff < CW'(2));
   assign stat.top_zero    = (top_ff == 32'd0);
   assign stat.div_done    = div_done;

   assign depth_wide  = {7'd0, depth_ff};
   assign stack_depth = depth_wide[6:0];
   assign top_value   = (depth_ff != '0) ? top_ff : 32'd0;

endmodule

>>> rtl/sau_control.sv
// Stack unit controller: sequences one operation at a time.
module sau_control import sau_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [2:0]  req_operation,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid,
   output logic [1:0]  status
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CHECK = 5'b00010,
      S_READ  = 5'b00100,
      S_DIVW  = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic [1:0] status_ff, status_in;
   logic       two_operand;

   assign two_operand = (op_ff == OP_ADD) || (op_ff == OP_SUB) || (op_ff == OP_DIV) ||
                        (op_ff == OP_MUL) || (op_ff == OP_SWAP);

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      status_in  = status_ff;
      cmd        = '0;
      cmd.alu_op = op_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load_req = 1'b1;
               op_in        = req_operation;
               state_in     = S_CHECK;
            end
         end
         S_CHECK: begin
            status_in = ST_OK;
            state_in  = S_RESP;
            priority if (op_ff == OP_PUSH) begin
               if (stat.full) begin
                  status_in = ST_FULL;
               end else begin
                  cmd.push = 1'b1;
               end
            end else if (two_operand) begin
               priority if (stat.short_stack) begin
                  status_in = ST_SHORT;
               end else if ((op_ff == OP_DIV) && stat.top_zero) begin
                  status_in = ST_DIVZERO;
               end else begin
                  cmd.rd_en = 1'b1;
                  state_in  = S_READ;
               end
            end else begin
               // unused codes: no operation
               status_in = ST_OK;
            end
         end
         S_READ: begin
            priority if (op_ff == OP_SWAP) begin
               cmd.swap = 1'b1;
               state_in = S_RESP;
            end else if (op_ff == OP_DIV) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIVW;
            end else begin
               cmd.arith = 1'b1;
               state_in  = S_RESP;
            end
         end
         S_DIVW: begin
            if (stat.div_done) begin
               cmd.div_load = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_RESP: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      status_ff <= status_in;
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign status    = status_ff;

endmodule

>>> rtl/stack_arithmetic_unit.sv
// Stack arithmetic unit top level: controller, datapath and checks.
//
//   channel   ports                          transfer when
//   request   start, busy, req_data          start && !busy
//   response  rsp_valid, rsp_data            rsp_valid (one cycle)
//
// Push, no-op and error cases pass through the CHECK and RESP states after the
// request transfer. Add, sub, mul and swap add a READ state for the registered
// stack memory read. Div adds READ and then DIVW, which waits for the 32-step
// divider. Synchronous reset empties the stack.
// The response cannot be stalled; busy holds off requests while an item runs.
`include "assert_macros.svh"

module stack_arithmetic_unit import sau_pkg::*; #(
   parameter int STACK_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [1:0]  status;
   logic [31:0] top_value;
   logic [6:0]  stack_depth;

   sau_control u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_operation (req_data.operation),
      .stat          (stat),
      .cmd           (cmd),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .status        (status)
   );

   sau_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .cmd         (cmd),
      .stat        (stat),
      .top_value   (top_value),
      .stack_depth (stack_depth)
   );

   assign rsp_data.status      = status;
   assign rsp_data.top_value   = top_value;
   assign rsp_data.stack_depth = stack_depth;

   `SAU_ASSERT(a_rsp_single, rsp_valid |=> !rsp_valid, "response strobe longer than one cycle")
   `SAU_ASSERT(a_accept_busy, (start && !busy) |=> busy, "request transfer did not raise busy")
   `SAU_ASSERT(a_err_depth, (rsp_valid && (rsp_data.status != ST_OK)) |-> $stable(rsp_data.stack_depth), "error response changed depth")
   `SAU_ASSERT_ALWAYS(a_reset_idle, reset |=> !busy && !rsp_valid, "not idle after reset")

endmodule
